// ===== hw/rtl/pfs_pkg.sv =====
package pfs_pkg;

    localparam int SYMBOL_W = 8;
    localparam int PREFIX_W = 12;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef enum logic [1:0] {
        MODE_START,
        MODE_OVF,
        MODE_SCAN
    } mode_t;

    typedef struct packed {
        logic [PREFIX_W-1:0] prefix_len;
        logic                overflow;
    } result_t;

endpackage

// ===== hw/rtl/pfs_ram.sv =====
module pfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/pfs_walk.sv =====
module pfs_walk #(
    parameter int MAX_LEN = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pfs_pkg::SYMBOL_W-1:0]   in_symbol,
    input  logic                           in_first,
    output logic                           res_valid,
    input  logic                           res_ready,
    output pfs_pkg::result_t               res
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int LW = (AW > pfs_pkg::PREFIX_W) ? AW : pfs_pkg::PREFIX_W;

    pfs_pkg::state_t state_reg, state_next;
    pfs_pkg::mode_t  mode_reg, mode_next;

    logic [pfs_pkg::SYMBOL_W-1:0] sym_reg;
    logic [AW-1:0]                len_reg, len_next;
    logic [PW-1:0]                pos_reg, pos_next;
    logic [AW-1:0]                last_border_reg, last_border_next;

    logic                         accept;
    logic                         match;
    logic                         step;
    logic                         finish;
    logic                         fire;
    logic [AW-1:0]                new_len;
    logic [LW-1:0]                new_len_wide;

    logic [AW-1:0]                rd_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                wr_border;
    logic [pfs_pkg::SYMBOL_W-1:0] sym_rdata;
    logic [AW-1:0]                brd_rdata;

    pfs_ram #(
        .WIDTH (pfs_pkg::SYMBOL_W),
        .DEPTH (MAX_LEN)
    ) u_symbol_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (sym_reg),
        .rd_addr (rd_addr),
        .rd_data (sym_rdata)
    );

    // Border of position len-1 is read alongside symbol len.
    pfs_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_LEN)
    ) u_border_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_border),
        .rd_addr (rd_addr - AW'(1)),
        .rd_data (brd_rdata)
    );

    assign in_ready = (state_reg == pfs_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign match   = (sym_rdata == sym_reg);
    assign step    = (state_reg == pfs_pkg::ST_WALK) && (mode_reg == pfs_pkg::MODE_SCAN)
                     && !match && (len_reg != '0);
    assign finish  = (state_reg == pfs_pkg::ST_WALK) && !step;
    assign fire    = finish && res_ready;
    assign new_len = match ? (len_reg + AW'(1)) : '0;
    assign new_len_wide = LW'(new_len);

    // Follow the chain straight from the border just read; otherwise hold the address.
    always_comb begin
        if (state_reg == pfs_pkg::ST_IDLE) begin
            rd_addr = last_border_reg;
        end else if (step) begin
            rd_addr = brd_rdata;
        end else begin
            rd_addr = len_reg;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        if (accept) begin
            if (in_first || (pos_reg == '0)) begin
                mode_next = pfs_pkg::MODE_START;
            end else if (pos_reg >= PW'(MAX_LEN)) begin
                mode_next = pfs_pkg::MODE_OVF;
            end else begin
                mode_next = pfs_pkg::MODE_SCAN;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pfs_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = pfs_pkg::ST_WALK;
                end
            end
            pfs_pkg::ST_WALK: begin
                if (fire) begin
                    state_next = pfs_pkg::ST_IDLE;
                end
            end
            default: state_next = pfs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        res_valid        = finish;
        res              = '0;
        wr_en            = 1'b0;
        wr_addr          = pos_reg[AW-1:0];
        wr_border        = new_len;
        pos_next         = pos_reg;
        last_border_next = last_border_reg;
        len_next         = len_reg;
        if (accept) begin
            len_next = last_border_reg;
        end else if (step) begin
            len_next = brd_rdata;
        end
        unique case (mode_reg)
            pfs_pkg::MODE_START: begin
                wr_en     = fire;
                wr_addr   = '0;
                wr_border = '0;
                if (fire) begin
                    pos_next         = PW'(1);
                    last_border_next = '0;
                end
            end
            pfs_pkg::MODE_OVF: begin
                res.overflow = 1'b1;
            end
            pfs_pkg::MODE_SCAN: begin
                res.prefix_len = new_len_wide[pfs_pkg::PREFIX_W-1:0];
                wr_en          = fire;
                if (fire) begin
                    pos_next         = pos_reg + PW'(1);
                    last_border_next = new_len;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= pfs_pkg::ST_IDLE;
            mode_reg        <= pfs_pkg::MODE_START;
            pos_reg         <= '0;
            last_border_reg <= '0;
            len_reg         <= '0;
        end else begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            pos_reg         <= pos_next;
            last_border_reg <= last_border_next;
            len_reg         <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sym_reg <= in_symbol;
        end
    end

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= PW'(MAX_LEN))
        else $error("position ran past the store depth");

    a_chain_below_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfs_pkg::ST_WALK) && (mode_reg == pfs_pkg::MODE_SCAN)
        |-> (PW'(len_reg) < pos_reg))
        else $error("border chain reached an unwritten position");

    a_chain_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> (len_reg < $past(len_reg)))
        else $error("border chain did not shrink");

    a_scan_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (mode_reg == pfs_pkg::MODE_SCAN) |=> (pos_reg == $past(pos_reg) + PW'(1)))
        else $error("position did not advance after a stored symbol");

    a_accept_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == pfs_pkg::ST_WALK) && (sym_reg == $past(in_symbol)))
        else $error("accepted request not captured");

endmodule

// ===== hw/rtl/prefix_function_stream_top.sv =====
// Streaming prefix function (KMP failure function): each request carries one byte and a
// start-of-string flag, and each yields one result with the length of the longest proper
// border of the string so far. Symbols and borders live in two MAX_LEN-deep memories; a
// string longer than MAX_LEN symbols returns overflow with a zero length until the next
// start flag. Each request falls back along the border chain until its symbol matches or the
// chain ends, one fallback step per read of the symbol and border memories. Fallback steps
// over a whole string never exceed its length. Start and overflow requests take no fallback
// steps. A new request is taken only after the previous result has gone to the output
// register. No clearing pass is needed after reset.
module prefix_function_stream_top #(
    parameter int MAX_LEN = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pfs_pkg::SYMBOL_W-1:0]  s_symbol,
    input  logic                          s_first,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pfs_pkg::PREFIX_W-1:0]  m_prefix_len,
    output logic                          m_overflow
);

    logic             res_valid;
    logic             res_ready;
    pfs_pkg::result_t res;
    pfs_pkg::result_t out_reg;
    logic             m_valid_reg;

    pfs_walk #(
        .MAX_LEN (MAX_LEN)
    ) u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_symbol (s_symbol),
        .in_first  (s_first),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Take a new result when the output register is empty or draining.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_prefix_len = out_reg.prefix_len;
    assign m_overflow   = out_reg.overflow;

endmodule
